// ----- rtl/pba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Transaction types, status codes and sequencer states for the pool block
// allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ERROR   = 2'd1,
        STATUS_CLEARED = 2'd2
    } status_t;

    typedef struct packed {
        logic        action;
        logic [11:0] request_length;
        logic [10:0] free_offset;
        logic        clear_on_failure;
    } req_t;

    typedef struct packed {
        logic [10:0] data_offset;
        status_t     status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/pool_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_block_allocator
// Tail-append, else first-fit, block allocator; list held in a rotating chain.
// ----------------------------------------------------------------------------
// The block list lives in a ring of MAX_BLOCKS cells that rotates by one
// entry per cycle while a pass runs, and every transaction drives it round
// twice, once to look at every entry and once to write the edited list back.
// One transaction is in flight at a time; a new request is taken as soon as
// the previous result sits in the output register, even if that result has
// not been collected yet. Status 0 is success, 1 failure with the list
// untouched, 2 failure with the pool cleared. After reset the pool is empty
// and ready at once.
module pool_block_allocator #(
    parameter int POOL_BYTES   = 2048,
    parameter int HEADER_BYTES = 7,
    parameter int MAX_BLOCKS   = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pba_pkg::rsp_t rsp
);

    // offsets reach POOL_BYTES at most; list index covers all cells
    localparam int SW = $clog2(POOL_BYTES + 1);
    localparam int IW = $clog2(MAX_BLOCKS);

    logic          advance;
    logic [SW-1:0] start_q [MAX_BLOCKS];
    logic          used_q  [MAX_BLOCKS];
    logic [SW-1:0] wrap_start;
    logic          wrap_used;

    // Ring of entries: cell 0 shows the entry under inspection, cell 1 the
    // one after it; whatever leaves cell 0 re-enters at the far end.
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        logic [SW-1:0] start_d;
        logic          used_d;
        if (k == MAX_BLOCKS - 1)
        begin : g_end
            assign start_d = wrap_start;
            assign used_d  = wrap_used;
        end
        else
        begin : g_mid
            assign start_d = start_q[k+1];
            assign used_d  = used_q[k+1];
        end
        pba_cell #(
            .SW (SW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .start_d (start_d),
            .used_d  (used_d),
            .start_q (start_q[k]),
            .used_q  (used_q[k])
        );
    end

    // Sequence the two passes and hold the result for the consumer
    pba_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .SW           (SW),
        .IW           (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .advance    (advance),
        .head_start (start_q[0]),
        .head_used  (used_q[0]),
        .next_start (start_q[1]),
        .next_used  (used_q[1]),
        .wrap_start (wrap_start),
        .wrap_used  (wrap_used)
    );

endmodule

// ----- rtl/pba_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_cell
// One list entry: block start offset and used mark, loaded from the
// neighbouring cell whenever the chain advances.
// ----------------------------------------------------------------------------
module pba_cell #(
    parameter int SW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [SW-1:0] start_d,
    input  logic          used_d,
    output logic [SW-1:0] start_q,
    output logic          used_q
);

    logic [SW-1:0] start_reg;
    logic          used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            used_reg  <= 1'b0;
        end
        else if (advance)
        begin
            start_reg <= start_d;
            used_reg  <= used_d;
        end
    end

    assign start_q = start_reg;
    assign used_q  = used_reg;

endmodule

// ----- rtl/pba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer: scans the rotating entry chain once to gather the decision,
// then rotates it once more while rewriting entries on their way round.
// ----------------------------------------------------------------------------
module pba_ctrl #(
    parameter int POOL_BYTES   = 2048,
    parameter int HEADER_BYTES = 7,
    parameter int MAX_BLOCKS   = 512,
    parameter int SW           = 12,
    parameter int IW           = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  pba_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pba_pkg::rsp_t   rsp,
    output logic            advance,
    input  logic [SW-1:0]   head_start,
    input  logic            head_used,
    input  logic [SW-1:0]   next_start,
    input  logic            next_used,
    output logic [SW-1:0]   wrap_start,
    output logic            wrap_used
);

    localparam int AW = ((SW > 12) ? SW : 12) + 2;
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] POOL = AW'(POOL_BYTES);
    localparam logic [IW+1:0] NBLK = (IW+2)'(MAX_BLOCKS);
    localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);

    pba_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   count_reg;
    pba_pkg::req_t   item_reg;
    pba_pkg::rsp_t   res_reg, res_next;
    pba_pkg::rsp_t   rsp_reg;
    logic            rsp_valid_reg;

    // scan results
    logic [SW-1:0]   tail_reg;
    logic            fit_found_reg;
    logic [IW-1:0]   fit_idx_reg;
    logic [AW-1:0]   fit_data_reg;
    logic            hit_found_reg;
    logic [IW-1:0]   hit_idx_reg;
    logic            hit_prev_used_reg;
    logic            hit_next_used_reg;
    logic [IW-1:0]   hit_trim_reg;
    logic [IW-1:0]   last_used1_reg;
    logic            prev_used_reg;

    // edit plan for the rewrite pass
    logic            set_en_reg, set_en_next;
    logic            clr_en_reg, clr_en_next;
    logic [IW-1:0]   op_idx_reg, op_idx_next;
    logic            drop_en_reg, drop_en_next;
    logic [IW-1:0]   drop_idx_reg, drop_idx_next;
    logic            app_en_reg, app_en_next;
    logic [SW-1:0]   app_start_reg, app_start_next;
    logic            wipe_en_reg, wipe_en_next;
    logic [IW-1:0]   new_count_reg, new_count_next;

    logic            accept;
    logic            load_rsp;
    logic            pass_end;
    logic            real_entry;
    logic [AW-1:0]   head_w, next_w, head_data, len_w, where_w, tail_w;
    logic            append_ok;
    logic            shift_src;
    logic [IW:0]     app_pos;

    assign head_w    = AW'(head_start);
    assign next_w    = AW'(next_start);
    assign head_data = head_w + HDR;
    assign len_w     = AW'(item_reg.request_length);
    assign where_w   = AW'(item_reg.free_offset);
    assign tail_w    = AW'(tail_reg);
    assign real_entry = idx_reg < count_reg;
    assign pass_end  = idx_reg == LAST;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pba_pkg::ST_IDLE:  if (req_valid) state_next = pba_pkg::ST_SCAN;
            pba_pkg::ST_SCAN:  if (pass_end) state_next = pba_pkg::ST_WRITE;
            pba_pkg::ST_WRITE: if (pass_end) state_next = pba_pkg::ST_DONE;
            pba_pkg::ST_DONE:  if (!rsp_valid_reg || rsp_ready) state_next = pba_pkg::ST_IDLE;
            default:           state_next = pba_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        advance   = 1'b0;
        load_rsp  = 1'b0;
        unique case (state_reg)
            pba_pkg::ST_IDLE:  req_ready = 1'b1;
            pba_pkg::ST_SCAN:  advance   = 1'b1;
            pba_pkg::ST_WRITE: advance   = 1'b1;
            pba_pkg::ST_DONE:  load_rsp  = !rsp_valid_reg || rsp_ready;
            default:           req_ready = 1'b0;
        endcase
    end

    assign accept = req_ready && req_valid;

    // decision, taken from the finished scan
    always_comb
    begin
        append_ok = (tail_w + HDR + HDR + len_w <= POOL) &&
                    ((IW+2)'(count_reg) + (IW+2)'(2) <= NBLK);
        set_en_next    = 1'b0;
        clr_en_next    = 1'b0;
        op_idx_next    = '0;
        drop_en_next   = 1'b0;
        drop_idx_next  = '0;
        app_en_next    = 1'b0;
        app_start_next = SW'(tail_w + HDR + len_w);
        wipe_en_next   = 1'b0;
        new_count_next = count_reg;
        res_next.data_offset = '0;
        res_next.status      = pba_pkg::STATUS_OK;
        if (item_reg.action == pba_pkg::ACT_ALLOC)
        begin
            if (append_ok)
            begin
                set_en_next    = 1'b1;
                op_idx_next    = count_reg;
                app_en_next    = 1'b1;
                new_count_next = count_reg + IW'(1);
                res_next.data_offset = 11'(tail_w + HDR);
            end
            else if (fit_found_reg)
            begin
                set_en_next = 1'b1;
                op_idx_next = fit_idx_reg;
                res_next.data_offset = 11'(fit_data_reg);
            end
            else
            begin
                res_next.status = pba_pkg::STATUS_ERROR;
            end
        end
        else if (!hit_found_reg)
        begin
            res_next.status = pba_pkg::STATUS_ERROR;
        end
        else if ((IW+1)'(hit_idx_reg) + (IW+1)'(1) == (IW+1)'(count_reg))
        begin
            new_count_next = hit_trim_reg;
        end
        else
        begin
            clr_en_next = 1'b1;
            op_idx_next = hit_idx_reg;
            if (hit_idx_reg != '0 && !hit_prev_used_reg)
            begin
                drop_en_next   = 1'b1;
                drop_idx_next  = hit_idx_reg;
                new_count_next = count_reg - IW'(1);
            end
            else if (!hit_next_used_reg)
            begin
                // next entry is real here, as the freed block is not the last
                drop_en_next   = 1'b1;
                drop_idx_next  = hit_idx_reg + IW'(1);
                new_count_next = count_reg - IW'(1);
            end
        end
        if (res_next.status == pba_pkg::STATUS_ERROR)
        begin
            set_en_next  = 1'b0;
            clr_en_next  = 1'b0;
            drop_en_next = 1'b0;
            app_en_next  = 1'b0;
            new_count_next = count_reg;
            if (item_reg.clear_on_failure)
            begin
                wipe_en_next    = 1'b1;
                new_count_next  = '0;
                res_next.status = pba_pkg::STATUS_CLEARED;
            end
        end
    end

    // entry written back at the end of the chain
    assign app_pos   = (IW+1)'(count_reg) + (IW+1)'(1);
    assign shift_src = (state_reg == pba_pkg::ST_WRITE) && drop_en_reg &&
                       (idx_reg >= drop_idx_reg);
    always_comb
    begin
        wrap_start = shift_src ? next_start : head_start;
        wrap_used  = shift_src ? next_used  : head_used;
        if (state_reg == pba_pkg::ST_WRITE)
        begin
            if (set_en_reg && idx_reg == op_idx_reg)
                wrap_used = 1'b1;
            // a freed entry that is dropped hands its slot to its successor
            if (clr_en_reg && idx_reg == op_idx_reg && !shift_src)
                wrap_used = 1'b0;
            if (idx_reg >= new_count_reg)
                wrap_used = 1'b0;
            if (app_en_reg && (IW+1)'(idx_reg) == app_pos)
                wrap_start = app_start_reg;
            if (wipe_en_reg && idx_reg == '0)
                wrap_start = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pba_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
                idx_reg <= pass_end ? '0 : idx_reg + IW'(1);
            if (state_reg == pba_pkg::ST_WRITE && pass_end)
                count_reg <= new_count_reg;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg       <= req;
            fit_found_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            last_used1_reg <= '0;
            prev_used_reg  <= 1'b0;
        end
        if (state_reg == pba_pkg::ST_SCAN)
        begin
            if (idx_reg == count_reg)
                tail_reg <= head_start;
            if (real_entry && !head_used && !fit_found_reg &&
                next_w >= head_data + len_w)
            begin
                fit_found_reg <= 1'b1;
                fit_idx_reg   <= idx_reg;
                fit_data_reg  <= head_data;
            end
            if (real_entry && !hit_found_reg && head_data == where_w)
            begin
                hit_found_reg     <= 1'b1;
                hit_idx_reg       <= idx_reg;
                hit_prev_used_reg <= prev_used_reg;
                hit_next_used_reg <= next_used;
                hit_trim_reg      <= last_used1_reg;
            end
            if (real_entry && head_used)
                last_used1_reg <= idx_reg + IW'(1);
            prev_used_reg <= head_used;
            if (pass_end)
            begin
                set_en_reg    <= set_en_next;
                clr_en_reg    <= clr_en_next;
                op_idx_reg    <= op_idx_next;
                drop_en_reg   <= drop_en_next;
                drop_idx_reg  <= drop_idx_next;
                app_en_reg    <= app_en_next;
                app_start_reg <= app_start_next;
                wipe_en_reg   <= wipe_en_next;
                new_count_reg <= new_count_next;
                res_reg       <= res_next;
            end
        end
        if (load_rsp)
            rsp_reg <= res_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
